@@ rtl/fpda_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fpda_pkg;

    localparam int POINT_POS_DEF = 16;
    localparam int VALUE_W       = 32;
    localparam int FRAC_W        = 4;
    localparam int FACTOR_W      = 30;
    localparam int PROD_W        = VALUE_W + FACTOR_W + 1;
    localparam int NUM_DIGITS    = 10;
    localparam int LEN_W         = 4;
    localparam int STEP_W        = $clog2(VALUE_W);

    localparam logic [FRAC_W-1:0] FRAC_RESET = 4'd2;
    localparam logic [FRAC_W-1:0] FRAC_MAX   = 4'd9;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;

    typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } fpda_bcd_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_CONV,
        ST_PREP,
        ST_EMIT
    } fpda_state_t;

    function automatic logic [FACTOR_W-1:0] pow10(input logic [FRAC_W-1:0] fd);
        logic [FACTOR_W-1:0] f;
        case (fd)
            4'd0:    f = 30'd1;
            4'd1:    f = 30'd10;
            4'd2:    f = 30'd100;
            4'd3:    f = 30'd1000;
            4'd4:    f = 30'd10000;
            4'd5:    f = 30'd100000;
            4'd6:    f = 30'd1000000;
            4'd7:    f = 30'd10000000;
            4'd8:    f = 30'd100000000;
            default: f = 30'd1000000000;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

@@ rtl/fpda_scale.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fpda_scale #(
    parameter int POINT_POS = fpda_pkg::POINT_POS_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 start,
    input  wire  [fpda_pkg::VALUE_W-1:0]        value,
    input  wire  [fpda_pkg::FACTOR_W-1:0]       factor,
    output logic                                done,
    output logic [fpda_pkg::VALUE_W-1:0]        scaled
);
    import fpda_pkg::*;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (POINT_POS - 1);

    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [PROD_W-1:0]  sum;
    logic [VALUE_W-1:0]        scaled_reg, scaled_next;
    logic                      mul_vld_reg, done_reg;

    assign prod_next   = $signed(value) * $signed({1'b0, factor});
    assign sum         = prod_reg + ROUND_HALF;
    // Taking bits above the fraction is the arithmetic shift; the top bits wrap away.
    assign scaled_next = sum[POINT_POS +: VALUE_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            mul_vld_reg <= start;
            done_reg    <= mul_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg   <= prod_next;
        scaled_reg <= scaled_next;
    end

    assign done   = done_reg;
    assign scaled = scaled_reg;

endmodule

`default_nettype wire

@@ rtl/fpda_bcd.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fpda_bcd (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             start,
    input  wire  [fpda_pkg::VALUE_W-1:0]    bin,
    output fpda_pkg::fpda_bcd_stat_t        stat,
    output fpda_pkg::bcd_t                  bcd
);
    import fpda_pkg::*;

    logic [VALUE_W-1:0] bin_reg, bin_next;
    bcd_t               bcd_reg, bcd_next, adj;
    logic [STEP_W-1:0]  cnt_reg;
    logic               run_reg, done_reg;

    // Shift-and-add-three: one bit of the binary word moves into the digits each cycle.
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
        {bcd_next, bin_next} = {adj, bin_reg} << 1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(VALUE_W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            bin_reg <= bin;
            bcd_reg <= '0;
        end else if (run_reg) begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
        end
    end

    assign stat.busy = run_reg;
    assign stat.done = done_reg;
    assign bcd       = bcd_reg;

endmodule

`default_nettype wire

@@ rtl/fixed_point_to_decimal_ascii.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Payload
// s_       in         tdata[31:0] value
// m_       out        tdata[7:0] ch, tdata[11:8] length, tlast last
// cfg_     in         data[3:0] decimal places
//
// An item passes through the multiply and rounding registers, the shift-and-add-three
// unit (32 steps, then a done pulse), a setup state and the emission of its characters
// (1 to 12), one character per cycle while m_tready is high. Reset is synchronous and
// active low; it sets the decimal places to 2. s_tready is low from the accepted request
// until its last character is loaded. A low m_tready holds the current character and
// pauses the emission.

module fixed_point_to_decimal_ascii #(
    parameter int POINT_POS = fpda_pkg::POINT_POS_DEF
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [31:0]                     s_tdata,   // [31:0] value
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [15:0]                     m_tdata,   // [7:0] ch, [11:8] length, [15:12] zero
    output logic                            m_tlast,   // last
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire  [fpda_pkg::FRAC_W-1:0]     cfg_data   // [3:0] decimal places
);
    import fpda_pkg::*;

    fpda_state_t          state_reg, state_next;
    logic [FRAC_W-1:0]    places_reg;
    logic [FRAC_W-1:0]    fd_eff, fd_reg;
    logic                 neg_reg;
    logic [LEN_W-1:0]     width_reg, width_next, total_reg, total_next;
    logic [LEN_W-1:0]     idx_reg, idx_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [7:0]           ch_reg, ch_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic                 last_reg, last_next;

    logic                 accept, load;
    logic                 scale_done;
    logic [VALUE_W-1:0]   scaled, mag;
    fpda_bcd_stat_t       bcd_stat;
    bcd_t                 bcd;
    logic [LEN_W-1:0]     nd, k, ip, pos;
    logic [7:0]           ch_calc;

    assign cfg_ready = 1'b1;
    assign fd_eff    = (places_reg > FRAC_MAX) ? FRAC_MAX : places_reg;
    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);

    fpda_scale #(.POINT_POS(POINT_POS)) u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .value   (s_tdata),
        .factor  (pow10(fd_eff)),
        .done    (scale_done),
        .scaled  (scaled)
    );

    assign mag = scaled[VALUE_W-1] ? (~scaled + 1'b1) : scaled;

    fpda_bcd u_bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (scale_done),
        .bin     (mag),
        .stat    (bcd_stat),
        .bcd     (bcd)
    );

    // Significant digit count, at least one.
    always_comb begin
        nd = LEN_W'(1);
        for (int i = 1; i < NUM_DIGITS; i++) begin
            if (bcd[i] != 4'd0) begin
                nd = LEN_W'(i + 1);
            end
        end
        width_next = (nd > fd_reg + 1'b1) ? nd : fd_reg + 1'b1;
        total_next = width_next + LEN_W'(neg_reg) + LEN_W'(fd_reg != '0);
    end

    // Character at the current index: sign, integer digits, point, fraction digits.
    always_comb begin
        k   = idx_reg - LEN_W'(neg_reg);
        ip  = width_reg - fd_reg;
        pos = '0;
        if (neg_reg && idx_reg == '0) begin
            ch_calc = CH_MINUS;
        end else if (k < ip) begin
            pos     = width_reg - 1'b1 - k;
            ch_calc = CH_ZERO + {4'd0, bcd[pos]};
        end else if (k == ip) begin
            ch_calc = CH_POINT;
        end else begin
            pos     = width_reg - k;
            ch_calc = CH_ZERO + {4'd0, bcd[pos]};
        end
    end

    assign load = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        ch_next       = ch_reg;
        len_next      = len_reg;
        last_next     = last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (scale_done) begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (bcd_stat.done) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                idx_next   = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (load) begin
                    m_tvalid_next = 1'b1;
                    ch_next       = ch_calc;
                    last_next     = (idx_reg == total_reg - 1'b1);
                    len_next      = last_next ? total_reg : '0;
                    idx_next      = idx_reg + 1'b1;
                    if (last_next) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            places_reg   <= FRAC_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                places_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        ch_reg   <= ch_next;
        len_reg  <= len_next;
        last_reg <= last_next;
        if (accept) begin
            fd_reg <= fd_eff;
        end
        if (scale_done) begin
            neg_reg <= scaled[VALUE_W-1];
        end
        if (state_reg == ST_PREP) begin
            width_reg <= width_next;
            total_reg <= total_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, len_reg, ch_reg};
    assign m_tlast  = last_reg;

`ifndef ASSERT_OFF
    a_len_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && last_reg |-> len_reg != '0)
        else $error("last character carries no length");

    a_len_zero_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !last_reg |-> len_reg == '0)
        else $error("length set on an inner character");

    a_idx_in_text: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> idx_reg < total_reg)
        else $error("character index beyond text length");

    a_conv_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        bcd_stat.done |-> state_reg == ST_CONV)
        else $error("conversion finished outside the conversion phase");

    a_width_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> width_reg <= LEN_W'(NUM_DIGITS))
        else $error("digit field wider than the decimal register");
`endif

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import fpda_pkg::*;

    localparam int FIX_FRAC  = POINT_POS_DEF;
    localparam int RUN_LIMIT = 400000;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic [3:0] len;
    } text_char_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_QUARTER,
        RX_SPARSE
    } rx_pattern_t;

    class decimal_text_tracker;
        logic [FRAC_W-1:0] frac = FRAC_RESET;
        text_char_t        pending[$];
        int                errors = 0;
        int                values = 0;
        int                chars = 0;
        int                negatives = 0;

        // Scaled value as the block keeps it: rounded, shifted and wrapped to 32 bits.
        function logic [31:0] scale(logic [31:0] v, int fd);
            longint factor;
            longint prod;
            factor = 1;
            for (int i = 0; i < fd; i++) factor *= 10;
            prod = longint'(signed'(v)) * factor + (longint'(1) <<< (FIX_FRAC - 1));
            prod = prod >>> FIX_FRAC;
            return prod[31:0];
        endfunction

        function void note_value(logic [31:0] v);
            int          fd;
            int          nd;
            int          width;
            logic [31:0] s;
            logic [31:0] mag;
            logic [3:0]  digs[10];
            logic [7:0]  txt[$];
            text_char_t  c;
            fd = (frac > FRAC_MAX) ? FRAC_MAX : frac;
            s = scale(v, fd);
            mag = s[31] ? -s : s;
            nd = 0;
            do begin
                digs[nd] = 4'(mag % 10);
                nd++;
                mag = mag / 10;
            end while (mag != 0 && nd < 10);
            width = (nd > fd + 1) ? nd : fd + 1;
            if (s[31]) begin
                txt.push_back(CH_MINUS);
                negatives++;
            end
            for (int pos = width - 1; pos >= 0; pos--) begin
                if (fd > 0 && pos + 1 == fd) txt.push_back(CH_POINT);
                txt.push_back(pos < nd ? 8'(CH_ZERO + digs[pos]) : CH_ZERO);
            end
            foreach (txt[i]) begin
                c.ch   = txt[i];
                c.last = (i == txt.size() - 1);
                c.len  = c.last ? 4'(txt.size()) : 4'd0;
                pending.push_back(c);
            end
            values++;
            chars += txt.size();
        endfunction

        function void check_char(logic [7:0] ch, logic last, logic [3:0] len);
            text_char_t e;
            if (pending.size() == 0) begin
                $error("character %h arrived with no text pending", ch);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (ch !== e.ch) begin
                $error("ch: expected %h, got %h", e.ch, ch);
                errors++;
            end
            if (last !== e.last) begin
                $error("last: expected %b, got %b", e.last, last);
                errors++;
            end
            if (len !== e.len) begin
                $error("length: expected %0d, got %0d", e.len, len);
                errors++;
            end
        endfunction

        function bit drained();
            return pending.size() == 0;
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [15:0]       m_tdata;
    logic              m_tlast;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [FRAC_W-1:0] cfg_data = '0;

    decimal_text_tracker sb = new;
    rx_pattern_t         rx_mode = RX_OPEN;
    int                  rx_left = 0;
    int                  burst_left = 0;
    int                  settings_written = 0;
    int                  cycles = 0;

    fixed_point_to_decimal_ascii #(
        .POINT_POS(FIX_FRAC)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("fixed_point_to_decimal_ascii verification failed");
            $finish;
        end
    end

    // The receiver keeps one stall pattern for a while, then picks another.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= rx_pattern_t'($urandom_range(0, 3));
                rx_left <= $urandom_range(30, 400);
            end else begin
                rx_left <= rx_left - 1;
            end
            case (rx_mode)
                RX_OPEN:    m_tready <= 1'b1;
                RX_COIN:    m_tready <= ($urandom_range(0, 1) == 1);
                RX_QUARTER: m_tready <= (rx_left[1:0] == 2'b00);
                default:    m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_char(m_tdata[7:0], m_tlast, m_tdata[11:8]);
    end

    task automatic send_value(input logic [31:0] v);
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
        sb.note_value(v);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30)
                                                      : $urandom_range(0, 6);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 70 : 6)) @(posedge aclk);
        end
    endtask

    task automatic drain_texts();
        s_tvalid <= 1'b0;
        while (!sb.drained()) @(posedge aclk);
    endtask

    task automatic write_frac(input logic [FRAC_W-1:0] fd);
        drain_texts();
        cfg_valid <= 1'b1;
        cfg_data  <= fd;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.frac = fd;
        settings_written++;
    endtask

    initial begin
        logic [31:0]       at_reset[12];
        logic [31:0]       whole_only[4];
        logic [31:0]       nine_digit[4];
        logic [FRAC_W-1:0] phase_frac[10];
        logic [31:0]       v;
        logic [31:0]       edge_val;
        int                edge_fd;
        longint            fct;
        longint            cand;
        int                sel;

        at_reset   = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'h0000_8000, 32'hFFFF_8000,
                       32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_FF9C,
                       32'hFFFF_FD00, 32'h0000_FFFF};
        whole_only = '{32'h0000_8000, 32'hFFFF_8000, 32'h7FFF_FFFF, 32'h8000_0000};
        nine_digit = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF};
        phase_frac = '{4'd1, 4'd4, 4'd0, 4'd9, 4'd12, 4'd6, 4'd3, 4'd8, 4'd7, 4'd15};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fraction digits left at their reset value.
        foreach (at_reset[i]) send_value(at_reset[i]);
        write_frac(4'd0);
        foreach (whole_only[i]) send_value(whole_only[i]);
        write_frac(4'd9);
        foreach (nine_digit[i]) send_value(nine_digit[i]);
        // Settings above nine behave as nine.
        write_frac(4'd15);
        send_value(32'h1234_5678);
        send_value(32'hFFFF_0000);

        // Look for an input whose scaled value wraps onto exactly the most negative number.
        edge_fd = 0;
        for (int fd = 5; fd <= 9 && edge_fd == 0; fd++) begin
            fct = 1;
            for (int i = 0; i < fd; i++) fct *= 10;
            for (int m = -15259; m <= 15259 && edge_fd == 0; m += 2) begin
                for (int d = -1; d <= 1; d++) begin
                    cand = ((longint'(m) <<< 47) / fct) + d;
                    if (edge_fd == 0 && cand >= -64'sd2147483648 && cand <= 64'sd2147483647 &&
                        sb.scale(cand[31:0], fd) == 32'h8000_0000) begin
                        edge_fd  = fd;
                        edge_val = cand[31:0];
                    end
                end
            end
        end
        if (edge_fd != 0) begin
            write_frac(4'(edge_fd));
            send_value(edge_val);
        end

        foreach (phase_frac[p]) begin
            write_frac(p == $size(phase_frac) - 1 ? 4'($urandom_range(0, 15)) : phase_frac[p]);
            for (int n = 0; n < 16; n++) begin
                if (p == 2 && n == 8) drain_texts();
                sel = $urandom_range(0, 3);
                case (sel)
                    0:       v = $urandom();
                    1:       v = $urandom_range(0, 32'h0003_FFFF);
                    2:       v = {16'($urandom_range(0, 32'h7FFF)), 16'h8000}
                                 + $urandom_range(0, 4) - 2;
                    default: v = $urandom_range(0, 2047);
                endcase
                if (sel != 0 && $urandom_range(0, 1) == 1) v = -v;
                send_value(v);
            end
        end

        drain_texts();
        repeat (60) @(posedge aclk);

        $display("Converted %0d values (%0d negative) into %0d characters.",
                 sb.values, sb.negatives, sb.chars);
        $display("Fraction digits were set %0d times, covering zero, nine and the clamped range.",
                 settings_written);
        if (sb.errors == 0 && sb.drained()) begin
            $display("fixed_point_to_decimal_ascii verification clean");
        end else begin
            $display("fixed_point_to_decimal_ascii verification failed");
        end
        $finish;
    end

endmodule
